// ===== design/block_cache_tag_store_lru_defines.svh =====
// Assertion macros used by the tag store design file.
`ifndef BLOCK_CACHE_TAG_STORE_LRU_DEFINES_SVH
`define BLOCK_CACHE_TAG_STORE_LRU_DEFINES_SVH

// Checked outside reset only.
`define BCTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every edge, reset included.
`define BCTS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== design/bcts_pkg.sv =====
package bcts_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int SLOT_W  = 5;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_READ    = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_PIN     = 2'd2,
		MODE_UNPIN   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] device;
		logic [31:0] blk;
		logic        valid;
		logic [15:0] count;
		logic [31:0] last_use;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_cmd_t;

	function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] s);
		logic [IDX_W+SLOT_W-1:0] w;
		w = {{IDX_W{1'b0}}, s};
		return w[IDX_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SLOT_W-1:0] w;
		w = {{SLOT_W{1'b0}}, idx};
		return w[SLOT_W-1:0];
	endfunction

	function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
		logic [IDX_W+SLOT_W-1:0] w;
		w = {{IDX_W{1'b0}}, s};
		return w < (IDX_W+SLOT_W)'(ENTRIES);
	endfunction

endpackage

// ===== design/bcts_if.sv =====
interface bcts_req_if import bcts_pkg::*; ();
	logic              valid;
	logic              ready;
	mode_t             mode;
	logic [31:0]       device;
	logic [31:0]       block_number;
	logic [SLOT_W-1:0] slot_index;
	logic [31:0]       now_tick;

	modport source (output valid, mode, device, block_number, slot_index, now_tick,
		input ready);
	modport sink (input valid, mode, device, block_number, slot_index, now_tick,
		output ready);
endinterface

interface bcts_rsp_if import bcts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot_out;
	logic              hit;
	logic              need_read;
	status_t           status;

	modport source (output valid, slot_out, hit, need_read, status, input ready);
	modport sink (input valid, slot_out, hit, need_read, status, output ready);
endinterface

// ===== design/bcts_ram.sv =====
module bcts_ram import bcts_pkg::*; (
	input  logic     clk,
	input  ram_cmd_t cmd,
	output entry_t   rdata
);

	entry_t mem [ENTRIES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		if (cmd.re) begin
			rdata_q <= mem[cmd.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/block_cache_tag_store_lru.sv =====
// Tag store of a disk block cache: per slot a (device, block) tag, valid flag,
// 16-bit reference count and last-use tick, all held in one single-port-read
// synchronous RAM of ENTRIES words.
// req channel: mode, device, block_number, slot_index, now_tick; a transfer
// happens when valid and ready are both high. rsp channel: slot_out, hit,
// need_read, status, one transfer per request, in request order.
// A read walks the RAM one slot per cycle, looking for the first tag match
// and the oldest unreferenced slot at once, then writes the chosen slot back
// unless its count is at the maximum or no unreferenced slot is found.
// Release, pin and unpin read one slot and write it back unless its count
// would underflow or overflow.
// One request is in flight at a time; req.ready rises again as soon as the
// result sits in the output register, so the next request is taken while the
// receiver stalls. A finished result waiting on a stalled receiver holds the
// write-back until rsp.ready, so nothing is lost.
// After reset the RAM is swept to zero, one slot per cycle, with req.ready low.
`include "block_cache_tag_store_lru_defines.svh"

module block_cache_tag_store_lru import bcts_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	bcts_req_if.sink   req,
	bcts_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_FETCH  = 4'b0100,
		S_UPDATE = 4'b1000
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [IDX_W:0]   END_CNT  = (IDX_W + 1)'(ENTRIES);

	state_t           state_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W:0]   issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	mode_t             mode_q;
	logic [31:0]       dev_q;
	logic [31:0]       blk_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       tick_q;

	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	entry_t           ent_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [31:0]      free_use_q;

	logic              rsp_vld_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic              hit_q;
	logic              need_q;
	status_t           status_q;

	ram_cmd_t ram_cmd;
	entry_t   rdata;

	logic              accept;
	logic              scanning;
	logic              tag_eq;
	logic              free_better;
	logic              upd_go;
	logic              upd_we;
	logic [IDX_W-1:0]  upd_idx;
	entry_t            upd_ent;
	logic [SLOT_W-1:0] res_slot;
	logic              res_hit;
	logic              res_need;
	status_t           res_status;

	bcts_ram u_ram (
		.clk   (clk),
		.cmd   (ram_cmd),
		.rdata (rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign scanning  = (state_q == S_FETCH) && (mode_q == MODE_READ);

	assign tag_eq      = (rdata.device == dev_q) && (rdata.blk == blk_q);
	assign free_better = (rdata.count == 16'd0) &&
		(!free_found_q || (rdata.last_use < free_use_q));

	assign upd_go = (state_q == S_UPDATE) && (!rsp_vld_q || rsp.ready);

	// The FSM serialises requests, so a read never overlaps a write-back.
	always_comb begin
		ram_cmd.re    = accept || (scanning && (issue_q != END_CNT));
		ram_cmd.raddr = issue_q[IDX_W-1:0];
		if (accept) begin
			ram_cmd.raddr = (req.mode == MODE_READ) ? '0 : to_idx(req.slot_index);
		end
		ram_cmd.we    = 1'b0;
		ram_cmd.waddr = upd_idx;
		ram_cmd.wdata = upd_ent;
		if (state_q == S_CLEAR) begin
			ram_cmd.we    = 1'b1;
			ram_cmd.waddr = clr_q;
			ram_cmd.wdata = '0;
		end else if (upd_go && upd_we) begin
			ram_cmd.we = 1'b1;
		end
	end

	always_comb begin
		upd_we     = 1'b0;
		upd_idx    = to_idx(slot_q);
		upd_ent    = ent_q;
		res_slot   = slot_q;
		res_hit    = 1'b0;
		res_need   = 1'b0;
		res_status = ST_OK;
		unique case (mode_q)
			MODE_READ: begin
				if (match_found_q) begin
					upd_idx  = match_idx_q;
					res_slot = to_slot(match_idx_q);
					res_hit  = 1'b1;
					if (ent_q.count == COUNT_MAX) begin
						res_status = ST_OVERFLOW;
					end else begin
						upd_we        = 1'b1;
						upd_ent.count = ent_q.count + 16'd1;
						upd_ent.valid = 1'b1;
						res_need      = !ent_q.valid;
					end
				end else if (free_found_q) begin
					upd_we           = 1'b1;
					upd_idx          = free_idx_q;
					upd_ent.device   = dev_q;
					upd_ent.blk      = blk_q;
					upd_ent.valid    = 1'b1;
					upd_ent.count    = 16'd1;
					upd_ent.last_use = '0;
					res_slot         = to_slot(free_idx_q);
					res_need         = 1'b1;
				end else begin
					res_slot   = '0;
					res_status = ST_NO_FREE;
				end
			end
			MODE_PIN: begin
				if (slot_ok(slot_q)) begin
					if (ent_q.count == COUNT_MAX) begin
						res_status = ST_OVERFLOW;
					end else begin
						upd_we        = 1'b1;
						upd_ent.count = ent_q.count + 16'd1;
					end
				end
			end
			MODE_RELEASE, MODE_UNPIN: begin
				if (slot_ok(slot_q)) begin
					if (ent_q.count == 16'd0) begin
						res_status = ST_UNDERFLOW;
					end else begin
						upd_we        = 1'b1;
						upd_ent.count = ent_q.count - 16'd1;
						// only a release that drops the last reference stamps the tick
						if (mode_q == MODE_RELEASE && ent_q.count == 16'd1) begin
							upd_ent.last_use = tick_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			issue_q       <= '0;
			rd_vld_s1     <= 1'b0;
			rd_idx_s1     <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			rsp_vld_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_cmd.re;
			rd_idx_s1 <= ram_cmd.raddr;
			if (ram_cmd.re && !accept) begin
				issue_q <= issue_q + 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q       <= S_FETCH;
						issue_q       <= (req.mode == MODE_READ) ? (IDX_W + 1)'(1) : END_CNT;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
					end
				end
				S_FETCH: begin
					if (rd_vld_s1 && scanning) begin
						if (!match_found_q && tag_eq) begin
							match_found_q <= 1'b1;
						end
						if (free_better) begin
							free_found_q <= 1'b1;
						end
						if (rd_idx_s1 == LAST_IDX) begin
							state_q <= S_UPDATE;
						end
					end else if (rd_vld_s1) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
			if (upd_go) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= req.mode;
			dev_q  <= req.device;
			blk_q  <= req.block_number;
			slot_q <= req.slot_index;
			tick_q <= req.now_tick;
		end
		if (state_q == S_FETCH && rd_vld_s1) begin
			if (scanning) begin
				if (!match_found_q && tag_eq) begin
					match_idx_q <= rd_idx_s1;
					ent_q       <= rdata;
				end
				if (free_better) begin
					free_idx_q <= rd_idx_s1;
					free_use_q <= rdata.last_use;
				end
			end else begin
				ent_q <= rdata;
			end
		end
		if (upd_go) begin
			slot_out_q <= res_slot;
			hit_q      <= res_hit;
			need_q     <= res_need;
			status_q   <= res_status;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.slot_out  = slot_out_q;
	assign rsp.hit       = hit_q;
	assign rsp.need_read = need_q;
	assign rsp.status    = status_q;

	`BCTS_ASSERT_ALWAYS(a_ram_write_phase, ram_cmd.we |-> (state_q == S_CLEAR || state_q == S_UPDATE), "RAM written outside sweep or write-back")
	`BCTS_ASSERT(a_accept_reads, accept |=> (state_q == S_FETCH && rd_vld_s1), "transfer did not start a RAM read")
	`BCTS_ASSERT(a_scan_ends, (scanning && rd_vld_s1 && rd_idx_s1 == LAST_IDX) |=> (state_q == S_UPDATE), "scan did not end at last slot")
	`BCTS_ASSERT(a_result_shown, upd_go |=> rsp.valid, "write-back gave no result")

endmodule
